// ===== sv/rsgp_pkg.sv =====
`default_nettype none

package rsgp_pkg;

  // field widths
  localparam int unsigned DEG_W = 6;
  localparam int unsigned LOG_W = 8;

  // primitive polynomial x^8 + x^4 + x^3 + x^2 + 1 and multiplicative group order
  localparam logic [8:0] GF_POLY  = 9'h11D;
  localparam logic [8:0] GF_ORDER = 9'd255;

  // coefficient in log form, zero flag stands for the zero element
  typedef struct packed {
    logic             zero;
    logic [LOG_W-1:0] lg;
  } coef_t;

  localparam coef_t COEF_ZERO = '{zero: 1'b1, lg: 8'd0};
  localparam coef_t COEF_ONE  = '{zero: 1'b0, lg: 8'd0};

  typedef logic [7:0] gf_table_t [256];

  // alpha^i, entry 255 wraps to alpha^0
  function automatic gf_table_t gf_antilog_build();
    gf_table_t  t;
    logic [8:0] v;
    v = 9'd1;
    for (int i = 0; i < 256; i++) begin
      t[i] = v[7:0];
      v = {v[7:0], 1'b0};
      if (v[8]) begin
        v = v ^ GF_POLY;
      end
    end
    return t;
  endfunction

  // inverse of the antilog table, entry 0 unused
  function automatic gf_table_t gf_log_build();
    gf_table_t  t;
    logic [8:0] v;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'd0;
    end
    v = 9'd1;
    for (int i = 0; i < 255; i++) begin
      t[v[7:0]] = 8'(i);
      v = {v[7:0], 1'b0};
      if (v[8]) begin
        v = v ^ GF_POLY;
      end
    end
    return t;
  endfunction

  localparam gf_table_t GF_ANTILOG = gf_antilog_build();
  localparam gf_table_t GF_LOG     = gf_log_build();

  // controller to datapath commands
  typedef struct packed {
    logic             init_wr;
    logic             rd_en;
    logic [DEG_W-1:0] rd_addr;
    logic             upd_valid;
    logic             src_zero;
    logic             first;
    logic [DEG_W-1:0] wr_addr;
    logic [DEG_W-1:0] step;
    logic             emit_ld;
    logic [DEG_W-1:0] emit_pow;
    logic             emit_last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/rsgp_ram.sv =====
`default_nettype none

// single port write, single port read, registered write-first read
module rsgp_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 33
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/rsgp_ctrl.sv =====
`default_nettype none

module rsgp_ctrl #(
  parameter int unsigned EFF_DEGREE = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic [rsgp_pkg::DEG_W-1:0]     degree_i,
  output logic                                in_ready_o,
  input  wire rsgp_pkg::status_t              status_i,
  output rsgp_pkg::cmd_t                      cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    INIT,
    UPD,
    EMIT_RD,
    EMIT_LD
  } state_e;

  state_e                      state_q;
  logic [rsgp_pkg::DEG_W-1:0]  n_q;   // saturated degree
  logic [rsgp_pkg::DEG_W-1:0]  i_q;   // current root index
  logic [rsgp_pkg::DEG_W-1:0]  k_q;   // coefficient being written or emitted
  logic [rsgp_pkg::DEG_W-1:0]  deg_sat;

  assign deg_sat = (degree_i > rsgp_pkg::DEG_W'(EFF_DEGREE)) ?
                   rsgp_pkg::DEG_W'(EFF_DEGREE) : degree_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      n_q     <= '0;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      case (state_q)
        IDLE: begin
          if (in_valid_i) begin
            n_q     <= deg_sat;
            state_q <= INIT;
          end
        end
        INIT: begin
          i_q <= '0;
          if (n_q == '0) begin
            k_q     <= '0;
            state_q <= EMIT_RD;
          end else begin
            k_q     <= rsgp_pkg::DEG_W'(1);
            state_q <= UPD;
          end
        end
        UPD: begin
          if (k_q == '0) begin
            if (i_q == n_q - rsgp_pkg::DEG_W'(1)) begin
              k_q     <= n_q;
              state_q <= EMIT_RD;
            end else begin
              i_q <= i_q + rsgp_pkg::DEG_W'(1);
              k_q <= i_q + rsgp_pkg::DEG_W'(2);
            end
          end else begin
            k_q <= k_q - rsgp_pkg::DEG_W'(1);
          end
        end
        EMIT_RD: begin
          if (status_i.out_free) begin
            state_q <= EMIT_LD;
          end
        end
        EMIT_LD: begin
          if (k_q == '0) begin
            state_q <= IDLE;
          end else begin
            k_q     <= k_q - rsgp_pkg::DEG_W'(1);
            state_q <= EMIT_RD;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.step      = i_q;
    cmd_o.wr_addr   = k_q;
    cmd_o.src_zero  = (k_q == '0);
    cmd_o.first     = (k_q == i_q + rsgp_pkg::DEG_W'(1));
    cmd_o.emit_pow  = k_q;
    cmd_o.emit_last = (k_q == '0);
    cmd_o.rd_addr   = k_q;
    case (state_q)
      INIT: begin
        cmd_o.init_wr = 1'b1;
      end
      UPD: begin
        cmd_o.upd_valid = 1'b1;
        cmd_o.rd_en     = (k_q != '0);
        cmd_o.rd_addr   = k_q - rsgp_pkg::DEG_W'(1);
      end
      EMIT_RD: begin
        cmd_o.rd_en = status_i.out_free;
      end
      EMIT_LD: begin
        cmd_o.emit_ld = 1'b1;
      end
      default: begin
        cmd_o.init_wr = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/rsgp_datapath.sv =====
`default_nettype none

module rsgp_datapath #(
  parameter int unsigned DEPTH = 33
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rsgp_pkg::cmd_t                cmd_i,
  output rsgp_pkg::status_t                  status_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [rsgp_pkg::DEG_W-1:0]         x_power_o,
  output logic [rsgp_pkg::LOG_W-1:0]         alpha_log_o,
  output logic                               is_zero_o,
  output logic                               last_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  // coefficient times alpha^e, log addition mod 255
  function automatic rsgp_pkg::coef_t gf_mul(input rsgp_pkg::coef_t c,
                                             input logic [rsgp_pkg::DEG_W-1:0] e);
    logic [8:0]      sum;
    rsgp_pkg::coef_t r;
    sum = {1'b0, c.lg} + {3'b000, e};
    if (sum >= rsgp_pkg::GF_ORDER) begin
      sum = sum - rsgp_pkg::GF_ORDER;
    end
    r.zero = c.zero;
    r.lg   = c.zero ? 8'd0 : sum[7:0];
    return r;
  endfunction

  // field addition through antilog, xor, log
  function automatic rsgp_pkg::coef_t gf_add(input rsgp_pkg::coef_t a,
                                             input rsgp_pkg::coef_t b);
    logic [7:0]      va;
    logic [7:0]      vb;
    logic [7:0]      s;
    rsgp_pkg::coef_t r;
    va = a.zero ? 8'd0 : rsgp_pkg::GF_ANTILOG[a.lg];
    vb = b.zero ? 8'd0 : rsgp_pkg::GF_ANTILOG[b.lg];
    s  = va ^ vb;
    if (s == 8'd0) begin
      r = rsgp_pkg::COEF_ZERO;
    end else begin
      r.zero = 1'b0;
      r.lg   = rsgp_pkg::GF_LOG[s];
    end
    return r;
  endfunction

  // stage 1: read data returns
  logic                        s1_valid_q;
  logic                        s1_src_zero_q;
  logic                        s1_first_q;
  logic [rsgp_pkg::DEG_W-1:0]  s1_wr_addr_q;
  logic [rsgp_pkg::DEG_W-1:0]  s1_step_q;
  rsgp_pkg::coef_t             prev_q;

  // stage 2: add and write back
  logic                        s2_valid_q;
  rsgp_pkg::coef_t             s2_data_q;
  rsgp_pkg::coef_t             s2_mul_q;
  logic [rsgp_pkg::DEG_W-1:0]  s2_wr_addr_q;

  logic                        out_valid_q;
  logic [rsgp_pkg::DEG_W-1:0]  x_power_q;
  logic [rsgp_pkg::LOG_W-1:0]  alpha_log_q;
  logic                        is_zero_q;
  logic                        last_q;

  logic [$bits(rsgp_pkg::coef_t)-1:0] rd_data;
  rsgp_pkg::coef_t             rd_coef;
  rsgp_pkg::coef_t             s1_data;
  rsgp_pkg::coef_t             s1_prev;
  rsgp_pkg::coef_t             s1_mul;
  rsgp_pkg::coef_t             s2_res;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  rsgp_pkg::coef_t             ram_wdata;

  assign rd_coef = rsgp_pkg::coef_t'(rd_data);
  assign s1_data = s1_src_zero_q ? rsgp_pkg::COEF_ZERO : rd_coef;
  assign s1_prev = s1_first_q ? rsgp_pkg::COEF_ZERO : prev_q;
  assign s1_mul  = gf_mul(s1_prev, s1_step_q);
  assign s2_res  = gf_add(s2_data_q, s2_mul_q);

  assign ram_we    = cmd_i.init_wr | s2_valid_q;
  assign ram_waddr = cmd_i.init_wr ? '0 : s2_wr_addr_q[AW-1:0];
  assign ram_wdata = cmd_i.init_wr ? rsgp_pkg::COEF_ONE : s2_res;

  rsgp_ram #(
    .WIDTH ($bits(rsgp_pkg::coef_t)),
    .DEPTH (DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.upd_valid;
      s2_valid_q <= s1_valid_q;
      if (cmd_i.emit_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_src_zero_q <= cmd_i.src_zero;
    s1_first_q    <= cmd_i.first;
    s1_wr_addr_q  <= cmd_i.wr_addr;
    s1_step_q     <= cmd_i.step;
    if (s1_valid_q) begin
      prev_q <= s1_data;
    end
    s2_data_q    <= s1_data;
    s2_mul_q     <= s1_mul;
    s2_wr_addr_q <= s1_wr_addr_q;
    if (cmd_i.emit_ld) begin
      x_power_q   <= cmd_i.emit_pow;
      alpha_log_q <= rd_coef.zero ? 8'd0 : rd_coef.lg;
      is_zero_q   <= rd_coef.zero;
      last_q      <= cmd_i.emit_last;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign x_power_o   = x_power_q;
  assign alpha_log_o = alpha_log_q;
  assign is_zero_o   = is_zero_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== sv/rs_generator_polynomial_core.sv =====
`default_nettype none

// Reed-Solomon generator polynomial over GF(256), primitive polynomial 0x11D.
// A request word carries the degree n (saturated to MAX_DEGREE); the core
// builds g(x) = product of (x + alpha^i), i = 0..n-1, in a coefficient RAM
// and returns n+1 words from x^n down to x^0, each the coefficient's log
// base alpha, a zero flag (log then reads 0) and last on x^0. Degree zero
// gives the single word x^0 with log 0. One request is processed at a time:
// the core takes the request, seeds the RAM, then runs the coefficient
// updates, one RAM read-modify-write per cycle through a two stage
// multiply/add pipe, then reads and loads each result word, holding the
// read while the output register is full and not being taken. The single
// read port of the coefficient RAM sets the pace of the updates. A new request
// is taken as soon as the last result word sits in the output register.
// The coefficient RAM needs no clearing after reset.
module rs_generator_polynomial_core #(
  parameter int unsigned MAX_DEGREE = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // request channel
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [rsgp_pkg::DEG_W-1:0]   degree_i,
  // coefficient channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [rsgp_pkg::DEG_W-1:0]        x_power_o,
  output logic [rsgp_pkg::LOG_W-1:0]        alpha_log_o,
  output logic                              is_zero_o,
  output logic                              last_o
);

  // the 6 bit degree field never asks for more than 63 roots
  localparam int unsigned DEG_MAX_IN = (1 << rsgp_pkg::DEG_W) - 1;
  localparam int unsigned EFF_DEGREE = (MAX_DEGREE < DEG_MAX_IN) ? MAX_DEGREE : DEG_MAX_IN;
  localparam int unsigned DEPTH      = EFF_DEGREE + 1;

  rsgp_pkg::cmd_t    cmd;
  rsgp_pkg::status_t status;

  // sequencer: seeds, walks roots and coefficients, then drains results
  rsgp_ctrl #(
    .EFF_DEGREE (EFF_DEGREE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .degree_i   (degree_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // coefficient RAM, GF multiply/add pipe and output register
  rsgp_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .x_power_o   (x_power_o),
    .alpha_log_o (alpha_log_o),
    .is_zero_o   (is_zero_o),
    .last_o      (last_o)
  );

`ifndef SYNTH
  // last marks the x^0 coefficient and nothing else
  a_last_at_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (x_power_o == '0)))
    else $error("last does not match x power zero");

  // a zero coefficient reports log 0
  a_zero_log: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_zero_o) |-> (alpha_log_o == '0))
    else $error("zero coefficient with nonzero log");

  // a taken request keeps the core busy
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while busy");

  // more words are still owed after a non-last word
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> !in_ready_o)
    else $error("request channel open in the middle of a run");
`endif

endmodule

`default_nettype wire
